// ===== rtl/siphash_pkg.sv =====
// siphash_pkg: shared types, constants and the SipRound function for the
// single-word SipHash block. No dependencies; used by every rtl file.
`default_nettype none

package siphash_pkg;

	localparam int WORD_W = 64;
	localparam int CFG_IDX_W = 8;
	localparam int CRND_W = 3;
	localparam int FRND_W = 4;

	localparam logic [WORD_W-1:0] SIP_INIT0 = 64'h736f6d6570736575;
	localparam logic [WORD_W-1:0] SIP_INIT1 = 64'h646f72616e646f6d;
	localparam logic [WORD_W-1:0] SIP_INIT2 = 64'h6c7967656e657261;
	localparam logic [WORD_W-1:0] SIP_INIT3 = 64'h7465646279746573;
	localparam logic [WORD_W-1:0] SIP_LEN_BLOCK = 64'h0800000000000000;
	localparam logic [WORD_W-1:0] SIP_FINAL_XOR = 64'h00000000000000ff;

	localparam logic [CRND_W-1:0] CRND_RESET = 3'd2;
	localparam logic [FRND_W-1:0] FRND_RESET = 4'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COMPRESS_ROUNDS = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FINAL_ROUNDS = 8'd3;

	typedef struct packed {
		logic [WORD_W-1:0] v0;
		logic [WORD_W-1:0] v1;
		logic [WORD_W-1:0] v2;
		logic [WORD_W-1:0] v3;
	} state_t;

	typedef struct packed {
		logic              valid;
		logic              eob;
		logic [WORD_W-1:0] msg;
		state_t            st;
	} pipe_t;

	typedef struct packed {
		logic [WORD_W-1:0] key_low;
		logic [WORD_W-1:0] key_high;
		logic [CRND_W-1:0] compress_rounds;
		logic [FRND_W-1:0] final_rounds;
	} cfg_t;

	function automatic logic [WORD_W-1:0] rotl13(input logic [WORD_W-1:0] x);
		rotl13 = {x[WORD_W-14:0], x[WORD_W-1:WORD_W-13]};
	endfunction

	function automatic logic [WORD_W-1:0] rotl16(input logic [WORD_W-1:0] x);
		rotl16 = {x[WORD_W-17:0], x[WORD_W-1:WORD_W-16]};
	endfunction

	function automatic logic [WORD_W-1:0] rotl17(input logic [WORD_W-1:0] x);
		rotl17 = {x[WORD_W-18:0], x[WORD_W-1:WORD_W-17]};
	endfunction

	function automatic logic [WORD_W-1:0] rotl21(input logic [WORD_W-1:0] x);
		rotl21 = {x[WORD_W-22:0], x[WORD_W-1:WORD_W-21]};
	endfunction

	function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x);
		rotl32 = {x[WORD_W-33:0], x[WORD_W-1:WORD_W-32]};
	endfunction

	// one SipRound, two adds deep
	function automatic state_t sip_round(input state_t s);
		logic [WORD_W-1:0] a1;
		logic [WORD_W-1:0] b1;
		logic [WORD_W-1:0] c1;
		logic [WORD_W-1:0] d1;
		logic [WORD_W-1:0] a2;
		logic [WORD_W-1:0] c2;
		state_t r;
		a1 = s.v0 + s.v1;
		b1 = rotl13(s.v1) ^ a1;
		c1 = s.v2 + s.v3;
		d1 = rotl16(s.v3) ^ c1;
		a2 = rotl32(a1) + d1;
		c2 = c1 + b1;
		r.v0 = a2;
		r.v3 = rotl21(d1) ^ a2;
		r.v1 = rotl17(b1) ^ c2;
		r.v2 = rotl32(c2);
		sip_round = r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/siphash_cfg.sv =====
// siphash_cfg: configuration register file (key halves and round counts).
// Depends on siphash_pkg.
`default_nettype none

module siphash_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                wr_en,
	input  wire logic [siphash_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire logic [siphash_pkg::WORD_W-1:0]      wr_data,
	output siphash_pkg::cfg_t                        cfg
);

	siphash_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_low <= '0;
			cfg_q.key_high <= '0;
			cfg_q.compress_rounds <= siphash_pkg::CRND_RESET;
			cfg_q.final_rounds <= siphash_pkg::FRND_RESET;
		end else if (wr_en) begin
			case (wr_index)
				siphash_pkg::REG_KEY_LOW: begin
					cfg_q.key_low <= wr_data;
				end
				siphash_pkg::REG_KEY_HIGH: begin
					cfg_q.key_high <= wr_data;
				end
				siphash_pkg::REG_COMPRESS_ROUNDS: begin
					cfg_q.compress_rounds <= wr_data[siphash_pkg::CRND_W-1:0];
				end
				siphash_pkg::REG_FINAL_ROUNDS: begin
					cfg_q.final_rounds <= wr_data[siphash_pkg::FRND_W-1:0];
				end
				default: begin
					// unknown index, write dropped
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/siphash_cell.sv =====
// siphash_cell: one registered SipRound slot of the round chain; applies the
// round when enabled, otherwise passes the state through. Depends on siphash_pkg.
`default_nettype none

module siphash_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               round_en,
	input  wire siphash_pkg::pipe_t in_item,
	output siphash_pkg::pipe_t      out_item
);

	logic                valid_s1;
	siphash_pkg::pipe_t  data_s1;
	siphash_pkg::state_t next_st;

	always_comb begin
		next_st = round_en ? siphash_pkg::sip_round(in_item.st) : in_item.st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_item.valid;
		end
	end

	always_ff @(posedge clk) begin
		data_s1.valid <= in_item.valid;
		data_s1.eob <= in_item.eob;
		data_s1.msg <= in_item.msg;
		data_s1.st <= next_st;
	end

	always_comb begin
		out_item = data_s1;
		out_item.valid = valid_s1;
	end

endmodule

`default_nettype wire

// ===== rtl/siphash_single_word.sv =====
// siphash_single_word: keyed SipHash-c-d of one 64-bit word per transaction.
// Depends on siphash_pkg, siphash_cfg and siphash_cell.
//
// Usage:
//   Input: a transaction is taken at a clock edge with start high and busy
//   low. busy is high only while reset is held and on the first edge after
//   release; after that every cycle can carry a new word.
//   Output: done pulses for one cycle with hash and batch_done; the receiver
//   cannot stall, so results simply leave the pipeline.
//   Config: cfg_valid/cfg_ready write port (cfg_ready always high), index 0
//   key_low, 1 key_high, 2 compress_rounds, 3 final_rounds; unknown indexes
//   are dropped. Write only while no word is in flight.
// Pipeline and throughput:
//   The round chain has 2*MAX_COMPRESS_ROUNDS + MAX_FINAL_ROUNDS cells, one
//   SipRound per cell; cells above the configured count pass the state on.
//   Each word passes the entry register, every cell and the output register,
//   independent of the round counts. One word per cycle.
// Reset: asynchronous, clears all valid bits and loads the register defaults.
`default_nettype none

module siphash_single_word #(
	parameter int MAX_COMPRESS_ROUNDS = 4,
	parameter int MAX_FINAL_ROUNDS = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [siphash_pkg::WORD_W-1:0]    message,
	input  wire logic                              end_of_batch,
	output logic                                   done,
	output logic [siphash_pkg::WORD_W-1:0]         hash,
	output logic                                   batch_done,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [siphash_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [siphash_pkg::WORD_W-1:0]    cfg_data
);

	localparam int NUM_CELLS = 2 * MAX_COMPRESS_ROUNDS + MAX_FINAL_ROUNDS;

	siphash_pkg::cfg_t  cfg;
	siphash_pkg::pipe_t link [0:NUM_CELLS];
	logic               busy_q;
	logic               accept;
	logic               valid_s0;
	siphash_pkg::pipe_t data_s0;
	logic               done_q;
	logic [siphash_pkg::WORD_W-1:0] hash_q;
	logic               batch_q;

	assign cfg_ready = 1'b1;

	siphash_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// hold off transactions until the first edge after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;
	assign accept = start & ~busy_q;

	// entry stage: keyed init state with the message folded into v3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else begin
			valid_s0 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		data_s0.valid <= accept;
		data_s0.eob <= end_of_batch;
		data_s0.msg <= message;
		data_s0.st.v0 <= siphash_pkg::SIP_INIT0 ^ cfg.key_low;
		data_s0.st.v1 <= siphash_pkg::SIP_INIT1 ^ cfg.key_high;
		data_s0.st.v2 <= siphash_pkg::SIP_INIT2 ^ cfg.key_low;
		data_s0.st.v3 <= siphash_pkg::SIP_INIT3 ^ cfg.key_high ^ message;
	end

	always_comb begin
		link[0] = data_s0;
		link[0].valid = valid_s0;
	end

	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		siphash_pkg::pipe_t cell_in;
		logic               round_en;

		always_comb begin
			cell_in = link[k];
			if (k == MAX_COMPRESS_ROUNDS) begin
				// end of message block, start of length block
				cell_in.st.v0 = link[k].st.v0 ^ link[k].msg;
				cell_in.st.v3 = link[k].st.v3 ^ siphash_pkg::SIP_LEN_BLOCK;
			end else if (k == 2 * MAX_COMPRESS_ROUNDS) begin
				// end of length block, start of finalization
				cell_in.st.v0 = link[k].st.v0 ^ siphash_pkg::SIP_LEN_BLOCK;
				cell_in.st.v2 = link[k].st.v2 ^ siphash_pkg::SIP_FINAL_XOR;
			end
		end

		// cells beyond the configured count pass through, which also saturates
		if (k < MAX_COMPRESS_ROUNDS) begin : g_msg
			assign round_en = 32'(cfg.compress_rounds) > 32'(k);
		end else if (k < 2 * MAX_COMPRESS_ROUNDS) begin : g_len
			assign round_en = 32'(cfg.compress_rounds) > 32'(k - MAX_COMPRESS_ROUNDS);
		end else begin : g_fin
			assign round_en = 32'(cfg.final_rounds) > 32'(k - 2 * MAX_COMPRESS_ROUNDS);
		end

		siphash_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.round_en (round_en),
			.in_item  (cell_in),
			.out_item (link[k+1])
		);
	end

	// output register: fold the four words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= link[NUM_CELLS].valid;
		end
	end

	always_ff @(posedge clk) begin
		hash_q <= link[NUM_CELLS].st.v0 ^ link[NUM_CELLS].st.v1
			^ link[NUM_CELLS].st.v2 ^ link[NUM_CELLS].st.v3;
		batch_q <= link[NUM_CELLS].eob & link[NUM_CELLS].valid;
	end

	assign done = done_q;
	assign hash = hash_q;
	assign batch_done = batch_q & done_q;

endmodule

`default_nettype wire

// ===== rtl/siphash_checker.sv =====
// siphash_checker: port-level checks on siphash_single_word, attached by bind.
// Depends on siphash_pkg and the top level's port list.
`default_nettype none

module siphash_checker #(
	parameter int MAX_COMPRESS_ROUNDS = 4,
	parameter int MAX_FINAL_ROUNDS = 8
) (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              start,
	input wire logic                              busy,
	input wire logic [siphash_pkg::WORD_W-1:0]    message,
	input wire logic                              end_of_batch,
	input wire logic                              done,
	input wire logic [siphash_pkg::WORD_W-1:0]    hash,
	input wire logic                              batch_done,
	input wire logic                              cfg_valid,
	input wire logic                              cfg_ready,
	input wire logic [siphash_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [siphash_pkg::WORD_W-1:0]    cfg_data
);

	localparam int LATENCY = 2 * MAX_COMPRESS_ROUNDS + MAX_FINAL_ROUNDS + 2;

	logic               accept;
	logic [LATENCY-1:0] accept_hist_q;

	assign accept = start & ~busy;

	// accepted transactions still in flight, cleared with the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accept_hist_q <= '0;
		end else begin
			accept_hist_q <= {accept_hist_q[LATENCY-2:0], accept};
		end
	end

	// every transaction yields exactly one result after a fixed latency
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done == accept_hist_q[LATENCY-1])
		else $error("done does not track accepted transactions");

	// the batch mark travels with its word
	a_batch_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> batch_done == $past(end_of_batch, LATENCY))
		else $error("batch_done does not match its transaction");

	a_batch_strobed: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !batch_done)
		else $error("batch_done high without done");

	// after reset settles, the pipeline never refuses a transaction
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> !busy)
		else $error("busy high outside reset");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind siphash_single_word siphash_checker #(
	.MAX_COMPRESS_ROUNDS (MAX_COMPRESS_ROUNDS),
	.MAX_FINAL_ROUNDS    (MAX_FINAL_ROUNDS)
) u_siphash_checker (.*);

`default_nettype wire

// ===== verif/siphash_single_word_tb.sv =====
// siphash_single_word_tb: self-checking bench for the single-word SipHash block.
// Depends on siphash_pkg and siphash_single_word; predicts each digest from a local
// SipRound model and checks every result in order against it.
module siphash_single_word_tb;
	import siphash_pkg::*;

	localparam int MAX_C = 4;
	localparam int MAX_F = 8;
	localparam int PIPE_DEPTH = 2 * MAX_C + MAX_F + 2;
	localparam int TIMEOUT = 2000000;
	localparam logic [CFG_IDX_W-1:0] UNMAPPED_LO_IDX = 8'd4;
	localparam logic [CFG_IDX_W-1:0] UNMAPPED_HI_IDX = 8'hff;
	localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

	typedef struct {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
		logic [WORD_W-1:0] d;
	} lanes_t;

	typedef struct {
		logic [WORD_W-1:0] message;
		logic              end_of_batch;
	} word_t;

	typedef struct {
		logic [WORD_W-1:0] hash;
		logic              batch_done;
	} digest_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [WORD_W-1:0]    message = '0;
	logic                 end_of_batch = 1'b0;
	logic                 done;
	logic [WORD_W-1:0]    hash;
	logic                 batch_done;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0]    cfg_data = '0;

	// shadow copy of the block's registers
	logic [WORD_W-1:0] key_lo = '0;
	logic [WORD_W-1:0] key_hi = '0;
	logic [CRND_W-1:0] comp_rounds = CRND_RESET;
	logic [FRND_W-1:0] fin_rounds = FRND_RESET;

	word_t   words_to_send[$];
	digest_t pending_digests[$];
	digest_t oldest;
	word_t   next_word;
	int      send_idle_pct = 0;
	int      error_count = 0;

	siphash_single_word #(
		.MAX_COMPRESS_ROUNDS(MAX_C),
		.MAX_FINAL_ROUNDS(MAX_F)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.message(message),
		.end_of_batch(end_of_batch),
		.done(done),
		.hash(hash),
		.batch_done(batch_done),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#(TIMEOUT);
		$display("FAILURE");
		$finish;
	end

	function automatic logic [WORD_W-1:0] rol64(input logic [WORD_W-1:0] x, input int n);
		return (x << n) | (x >> (WORD_W - n));
	endfunction

	function automatic lanes_t mix_round(input lanes_t s);
		s.a = s.a + s.b; s.b = rol64(s.b, 13) ^ s.a; s.a = rol64(s.a, 32);
		s.c = s.c + s.d; s.d = rol64(s.d, 16) ^ s.c;
		s.a = s.a + s.d; s.d = rol64(s.d, 21) ^ s.a;
		s.c = s.c + s.b; s.b = rol64(s.b, 17) ^ s.c; s.c = rol64(s.c, 32);
		return s;
	endfunction

	function automatic logic [WORD_W-1:0] sip_digest(input logic [WORD_W-1:0] word);
		lanes_t s;
		int c_n;
		int f_n;
		logic [WORD_W-1:0] blk;
		c_n = (comp_rounds > MAX_C) ? MAX_C : int'(comp_rounds);
		f_n = (fin_rounds > MAX_F) ? MAX_F : int'(fin_rounds);
		s.a = SIP_INIT0 ^ key_lo;
		s.b = SIP_INIT1 ^ key_hi;
		s.c = SIP_INIT2 ^ key_lo;
		s.d = SIP_INIT3 ^ key_hi;
		// message word, then the length block for an 8-byte message
		for (int i = 0; i < 2; i++) begin
			blk = (i == 0) ? word : SIP_LEN_BLOCK;
			s.d ^= blk;
			repeat (c_n) s = mix_round(s);
			s.a ^= blk;
		end
		s.c ^= SIP_FINAL_XOR;
		repeat (f_n) s = mix_round(s);
		return s.a ^ s.b ^ s.c ^ s.d;
	endfunction

	// driver: one transaction per accepting edge, random gaps between them
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				pending_digests.push_back('{hash: sip_digest(message), batch_done: end_of_batch});
			end
			if ((start && !busy) || !start) begin
				if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_word = words_to_send.pop_front();
					start <= 1'b1;
					message <= next_word.message;
					end_of_batch <= next_word.end_of_batch;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: results cannot be held off, so take each strobe as it comes
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_digests.size() == 0) begin
				$error("result with no transaction outstanding: hash %h batch_done %b",
					hash, batch_done);
				error_count++;
			end else begin
				oldest = pending_digests.pop_front();
				if (hash !== oldest.hash) begin
					$error("hash: expected %h, actual %h", oldest.hash, hash);
					error_count++;
				end
				if (batch_done !== oldest.batch_done) begin
					$error("batch_done: expected %b, actual %b", oldest.batch_done, batch_done);
					error_count++;
				end
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_KEY_LOW: key_lo = data;
			REG_KEY_HIGH: key_hi = data;
			REG_COMPRESS_ROUNDS: comp_rounds = data[CRND_W-1:0];
			REG_FINAL_ROUNDS: fin_rounds = data[FRND_W-1:0];
			default: ;
		endcase
	endtask

	task automatic queue_word(input logic [WORD_W-1:0] msg, input logic eob);
		words_to_send.push_back('{message: msg, end_of_batch: eob});
	endtask

	// wait until every word went in and every digest came back
	task automatic drain();
		do @(negedge clk);
		while (words_to_send.size() != 0 || start || pending_digests.size() != 0);
	endtask

	function automatic logic [WORD_W-1:0] random_word();
		int unsigned bit_pos;
		bit_pos = $urandom_range(WORD_W - 1);
		case ($urandom_range(9))
			0: return '0;
			1: return ALL_ONES;
			2: return {{(WORD_W-1){1'b0}}, 1'b1} << bit_pos;
			3: return ~({{(WORD_W-1){1'b0}}, 1'b1} << bit_pos);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] random_key();
		case ($urandom_range(3))
			0: return '0;
			1: return ALL_ONES;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic random_segment(input int n_words);
		write_reg(REG_KEY_LOW, random_key());
		write_reg(REG_KEY_HIGH, random_key());
		// full random data: the low bits pick the count, upper bits must be dropped
		write_reg(REG_COMPRESS_ROUNDS, {$urandom, $urandom});
		write_reg(REG_FINAL_ROUNDS, {$urandom, $urandom});
		if ($urandom_range(3) == 0)
			write_reg(CFG_IDX_W'($urandom_range(UNMAPPED_HI_IDX, UNMAPPED_LO_IDX)),
				{$urandom, $urandom});
		for (int i = 0; i < n_words; i++)
			queue_word(random_word(), $urandom_range(7) == 0);
		drain();
	endtask

	initial begin
		send_idle_pct = 19;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// register defaults after reset
		queue_word('0, 1'b0);
		queue_word(ALL_ONES, 1'b1);
		drain();

		// writes to unmapped indexes must leave the registers alone
		write_reg(UNMAPPED_LO_IDX, ALL_ONES);
		write_reg(UNMAPPED_HI_IDX, ALL_ONES);
		queue_word(64'h0123456789abcdef, 1'b0);
		queue_word(64'h8000000000000001, 1'b1);
		drain();

		// zero rounds in both phases, upper data bits dropped
		write_reg(REG_KEY_LOW, ALL_ONES);
		write_reg(REG_KEY_HIGH, ALL_ONES);
		write_reg(REG_COMPRESS_ROUNDS, 64'hfffffffffffffff8);
		write_reg(REG_FINAL_ROUNDS, 64'hfffffffffffffff0);
		queue_word(64'h5555555555555555, 1'b0);
		queue_word(64'haaaaaaaaaaaaaaaa, 1'b1);
		drain();

		// counts well above the maximum saturate
		write_reg(REG_KEY_LOW, 64'h0706050403020100);
		write_reg(REG_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
		write_reg(REG_COMPRESS_ROUNDS, 64'd7);
		write_reg(REG_FINAL_ROUNDS, 64'd15);
		queue_word(64'h0706050403020100, 1'b0);
		queue_word(ALL_ONES, 1'b1);
		drain();

		// just above the maximum
		write_reg(REG_COMPRESS_ROUNDS, 64'd5);
		write_reg(REG_FINAL_ROUNDS, 64'd9);
		queue_word('0, 1'b1);
		queue_word(64'hdeadbeefcafef00d, 1'b0);
		drain();

		// exactly the maximum
		write_reg(REG_COMPRESS_ROUNDS, 64'd4);
		write_reg(REG_FINAL_ROUNDS, 64'd8);
		queue_word(64'h0000000100000000, 1'b0);
		queue_word(64'hfffffffeffffffff, 1'b1);
		drain();

		// minimum nonzero counts
		write_reg(REG_KEY_LOW, '0);
		write_reg(REG_COMPRESS_ROUNDS, 64'd1);
		write_reg(REG_FINAL_ROUNDS, 64'd1);
		queue_word(64'h00000000000000ff, 1'b0);
		queue_word(64'hff00000000000000, 1'b1);
		drain();

		// random part: sender gaps at 19%, then 82%, then none
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 82 : 0;
			for (int seg = 0; seg < 4; seg++)
				random_segment(78);
		end

		// catch any stray result after the last expected one
		repeat (PIPE_DEPTH + 4) @(posedge clk);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
